// File: rtl/ppsu_pkg.sv
// Shared types, codes and helpers for the packed pixel sample unpacker.
package ppsu_pkg;

    // Depth register codes
    localparam logic [2:0] DEPTH_CODE_1  = 3'd0;
    localparam logic [2:0] DEPTH_CODE_2  = 3'd1;
    localparam logic [2:0] DEPTH_CODE_4  = 3'd2;
    localparam logic [2:0] DEPTH_CODE_8  = 3'd3;
    localparam logic [2:0] DEPTH_CODE_16 = 3'd4;

    // Log2 of the sample width in bits
    localparam logic [2:0] LG_1  = 3'd0;
    localparam logic [2:0] LG_2  = 3'd1;
    localparam logic [2:0] LG_4  = 3'd2;
    localparam logic [2:0] LG_8  = 3'd3;
    localparam logic [2:0] LG_16 = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DEPTH_CODE    = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH     = 2'd2;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [2:0] MAX_CHANNELS = 3'd4;

    // Byte queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // Wide enough for row_width and any MAX_WIDTH up to 65536
    localparam int unsigned WIDE_CNT_W = 17;

    typedef logic [15:0] qword_t;

    typedef struct packed {
        logic [2:0]  depth_code;
        logic [2:0]  channel_count;
        logic [12:0] row_width;
    } cfg_t;

    typedef struct packed {
        logic   push;
        qword_t data;
    } q_wr_t;

    // Undefined depth codes behave as 8 bits
    function automatic logic [2:0] depth_lg(input logic [2:0] code);
        logic [2:0] lg;
        case (code)
            DEPTH_CODE_1:  lg = LG_1;
            DEPTH_CODE_2:  lg = LG_2;
            DEPTH_CODE_4:  lg = LG_4;
            DEPTH_CODE_16: lg = LG_16;
            default:       lg = LG_8;
        endcase
        return lg;
    endfunction

endpackage

// File: rtl/packed_pixel_sample_unpacker_top.sv
// Top level of the packed pixel sample unpacker: configuration registers and wiring.
//
// Input channel s_*: one byte of an unfiltered PNG scanline per transaction.
// Output channel m_*: one unpacked channel sample per transaction, with its
// channel and pixel index, a flag on the last sample of each input byte and
// a flag on the last sample of the scanline. Padding bits after a row's last
// sample are dropped.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write depth_code (0), channel_count
// (1) and row_width (2); write only while the block is idle.
// A byte accepted is written into the byte queue; its first sample then passes into the output register.
// Throughput, while the receiver does not stall: depth 8 takes one byte per cycle,
// depth 16 two bytes per sample; below 8 bits a byte yields 8/depth samples
// (fewer at a row end), one sample per cycle through the single output register.
// A two-entry byte queue separates the input side from the sample splitter, so
// input is taken while a sample waits on a stalled receiver until the queue fills.
// Reset (aresetn low, synchronous) restores depth 8, one channel, row width 1,
// clears the counters and any held high byte, and empties the queue.
module packed_pixel_sample_unpacker_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ppsu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ppsu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_row_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_sample,
    output logic [1:0]                          m_channel_index,
    output logic [11:0]                         m_pixel_index,
    output logic                                m_last_of_byte,
    output logic                                m_row_end
);

    ppsu_pkg::cfg_t   cfg_reg;
    ppsu_pkg::cfg_t   cfg_next;
    ppsu_pkg::q_wr_t  q_wr;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    ppsu_pkg::qword_t q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                ppsu_pkg::REG_DEPTH_CODE:    cfg_next.depth_code    = cfg_wdata[2:0];
                ppsu_pkg::REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_wdata[2:0];
                ppsu_pkg::REG_ROW_WIDTH:     cfg_next.row_width     = cfg_wdata[12:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_code    <= ppsu_pkg::DEPTH_CODE_8;
            cfg_reg.channel_count <= 3'd1;
            cfg_reg.row_width     <= 13'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row_byte (s_row_byte),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    ppsu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_pop   (q_pop),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    ppsu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_channel_index (m_channel_index),
        .m_pixel_index   (m_pixel_index),
        .m_last_of_byte  (m_last_of_byte),
        .m_row_end       (m_row_end)
    );

endmodule

// File: rtl/ppsu_front.sv
// Front end: accepts scanline bytes, pairs 16-bit halves and feeds the byte queue.
module ppsu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppsu_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_row_byte,
    input  logic                q_full,
    output ppsu_pkg::q_wr_t     q_wr
);

    logic       wide;
    logic       accept;
    logic [7:0] hold_reg;
    logic [7:0] hold_next;
    logic       wide_phase_reg;
    logic       wide_phase_next;

    assign wide    = (ppsu_pkg::depth_lg(cfg.depth_code) == ppsu_pkg::LG_16);
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hold_next       = hold_reg;
        wide_phase_next = wide_phase_reg;
        q_wr.push       = 1'b0;
        q_wr.data       = {8'h00, s_row_byte};
        if (accept) begin
            if (wide) begin
                if (!wide_phase_reg) begin
                    // hold the high byte until its partner arrives
                    hold_next       = s_row_byte;
                    wide_phase_next = 1'b1;
                end else begin
                    wide_phase_next = 1'b0;
                    q_wr.push       = 1'b1;
                    q_wr.data       = {hold_reg, s_row_byte};
                end
            end else begin
                // drop any pending high byte
                wide_phase_next = 1'b0;
                q_wr.push       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg       <= 8'h00;
            wide_phase_reg <= 1'b0;
        end else begin
            hold_reg       <= hold_next;
            wide_phase_reg <= wide_phase_next;
        end
    end

endmodule

// File: rtl/ppsu_fifo.sv
// Short queue of bytes and 16-bit byte pairs between front and back.
module ppsu_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppsu_pkg::q_wr_t     q_wr,
    input  logic                q_pop,
    output logic                q_full,
    output logic                q_valid,
    output ppsu_pkg::qword_t    q_head
);

    ppsu_pkg::qword_t                mem_reg [ppsu_pkg::Q_DEPTH];
    logic [ppsu_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [ppsu_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [ppsu_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [ppsu_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [ppsu_pkg::Q_CNT_W-1:0]    count_reg;
    logic [ppsu_pkg::Q_CNT_W-1:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_full  = (count_reg == ppsu_pkg::Q_CNT_W'(ppsu_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_wr.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

endmodule

// File: rtl/ppsu_back.sv
// Back end: splits queued bytes into samples, tags them and drives the output register.
module ppsu_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppsu_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  ppsu_pkg::qword_t    q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_sample,
    output logic [1:0]          m_channel_index,
    output logic [11:0]         m_pixel_index,
    output logic                m_last_of_byte,
    output logic                m_row_end
);

    localparam int PIX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW    = ppsu_pkg::WIDE_CNT_W;

    logic [2:0]       lg;
    logic [2:0]       k_max;
    logic [2:0]       shamt;
    logic [7:0]       shifted;
    logic [15:0]      sample_c;
    logic [2:0]       eff_ch;
    logic [CW-1:0]    eff_w;
    logic [CW-1:0]    pix_ext;
    logic             ch_last;
    logic             pix_last;
    logic             row_end_c;
    logic             emit;

    logic [2:0]       k_reg;
    logic [2:0]       k_next;
    logic [1:0]       ch_reg;
    logic [1:0]       ch_next;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [15:0]      m_sample_reg;
    logic [1:0]       m_channel_index_reg;
    logic [11:0]      m_pixel_index_reg;
    logic             m_last_of_byte_reg;
    logic             m_row_end_reg;

    assign lg = ppsu_pkg::depth_lg(cfg.depth_code);

    always_comb begin
        case (lg)
            ppsu_pkg::LG_1: begin
                k_max = 3'd7;
                shamt = k_reg;
            end
            ppsu_pkg::LG_2: begin
                k_max = 3'd3;
                shamt = {k_reg[1:0], 1'b0};
            end
            ppsu_pkg::LG_4: begin
                k_max = 3'd1;
                shamt = {k_reg[0], 2'b00};
            end
            default: begin
                k_max = 3'd0;
                shamt = 3'd0;
            end
        endcase
    end

    assign shifted = q_head[7:0] << shamt;

    always_comb begin
        case (lg)
            ppsu_pkg::LG_1:  sample_c = {15'd0, shifted[7]};
            ppsu_pkg::LG_2:  sample_c = {14'd0, shifted[7:6]};
            ppsu_pkg::LG_4:  sample_c = {12'd0, shifted[7:4]};
            ppsu_pkg::LG_16: sample_c = q_head;
            default:         sample_c = {8'd0, q_head[7:0]};
        endcase
    end

    // Clamp channel count and row width into their legal ranges
    always_comb begin
        if (cfg.channel_count == 3'd0) begin
            eff_ch = 3'd1;
        end else if (cfg.channel_count > ppsu_pkg::MAX_CHANNELS) begin
            eff_ch = ppsu_pkg::MAX_CHANNELS;
        end else begin
            eff_ch = cfg.channel_count;
        end
        if (cfg.row_width == 13'd0) begin
            eff_w = CW'(1);
        end else if (CW'(cfg.row_width) > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(cfg.row_width);
        end
    end

    assign pix_ext   = CW'(pix_reg);
    assign ch_last   = ({1'b0, ch_reg} + 3'd1) >= eff_ch;
    assign pix_last  = (pix_ext + CW'(1)) >= eff_w;
    assign row_end_c = ch_last && pix_last;

    assign emit  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = emit && ((k_reg == k_max) || row_end_c);

    always_comb begin
        k_next       = k_reg;
        ch_next      = ch_reg;
        pix_next     = pix_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            // advance within the byte, or restart on the next one
            k_next = q_pop ? 3'd0 : k_reg + 3'd1;
            if (ch_last) begin
                ch_next  = 2'd0;
                pix_next = pix_last ? '0 : PIX_W'(pix_ext + CW'(1));
            end else begin
                ch_next = ch_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= 3'd0;
            ch_reg      <= 2'd0;
            pix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            ch_reg      <= ch_next;
            pix_reg     <= pix_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_sample_reg        <= sample_c;
            m_channel_index_reg <= ch_reg;
            m_pixel_index_reg   <= pix_ext[11:0];
            m_last_of_byte_reg  <= q_pop;
            m_row_end_reg       <= row_end_c;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample        = m_sample_reg;
    assign m_channel_index = m_channel_index_reg;
    assign m_pixel_index   = m_pixel_index_reg;
    assign m_last_of_byte  = m_last_of_byte_reg;
    assign m_row_end       = m_row_end_reg;

    a_row_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && row_end_c |=> (pix_reg == '0) && (ch_reg == 2'd0))
        else $error("counters not cleared after row end");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (k_reg <= k_max))
        else $error("sample index past end of byte");

    a_k_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !q_pop |=> (k_reg == $past(k_reg) + 3'd1))
        else $error("sample index did not advance within byte");

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid && (m_last_of_byte == $past(q_pop)))
        else $error("last_of_byte does not match queue pop");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the packed pixel sample unpacker: random and directed scanlines.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX       = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_BYTES  = 180;

    // Depth codes the register accepts but does not define; they run as 8 bits
    localparam logic [2:0] DEPTH_CODE_SPARE5 = 3'd5;
    localparam logic [2:0] DEPTH_CODE_SPARE6 = 3'd6;
    localparam logic [2:0] DEPTH_CODE_SPARE7 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef logic [7:0] row_bytes_t[$];

    typedef struct {
        logic [15:0] value;
        logic [1:0]  chan;
        logic [11:0] pix;
        logic        last_b;
        logic        row_end;
    } sample_t;

    class sample_scoreboard;
        logic [2:0]  depth_code;
        logic [2:0]  chan_cfg;
        logic [12:0] width_cfg;
        logic [11:0] pix_cnt;
        logic [1:0]  chan_cnt;
        logic [7:0]  hold_byte;
        logic        wide;
        sample_t     expected_q[$];
        int          errors;
        int          checked;
        int          bytes_seen;

        function new();
            depth_code = ppsu_pkg::DEPTH_CODE_8;
            chan_cfg   = 3'd1;
            width_cfg  = 13'd1;
            pix_cnt    = '0;
            chan_cnt   = '0;
            hold_byte  = '0;
            wide       = 1'b0;
            errors     = 0;
            checked    = 0;
            bytes_seen = 0;
        endfunction

        function void write_reg(logic [ppsu_pkg::CFG_ADDR_W-1:0] idx,
                                logic [ppsu_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                ppsu_pkg::REG_DEPTH_CODE:    depth_code = val[2:0];
                ppsu_pkg::REG_CHANNEL_COUNT: chan_cfg   = val[2:0];
                ppsu_pkg::REG_ROW_WIDTH:     width_cfg  = val[12:0];
                default: ;
            endcase
        endfunction

        // Queue one expected sample and advance the channel and pixel counters
        function void push_sample(logic [15:0] v, output bit at_end);
            int      nch;
            int      nw;
            sample_t s;
            nch = (chan_cfg == 0) ? 1 : int'(chan_cfg);
            if (nch > int'(ppsu_pkg::MAX_CHANNELS)) nch = int'(ppsu_pkg::MAX_CHANNELS);
            nw = (width_cfg == 0) ? 1 : int'(width_cfg);
            if (nw > ROW_MAX) nw = ROW_MAX;
            s.value   = v;
            s.chan    = chan_cnt;
            s.pix     = pix_cnt;
            s.last_b  = 1'b0;
            s.row_end = 1'b0;
            at_end    = 1'b0;
            if (int'(chan_cnt) + 1 >= nch) begin
                chan_cnt = '0;
                if (int'(pix_cnt) + 1 >= nw) begin
                    pix_cnt   = '0;
                    s.row_end = 1'b1;
                    at_end    = 1'b1;
                end else begin
                    pix_cnt = pix_cnt + 12'd1;
                end
            end else begin
                chan_cnt = chan_cnt + 2'd1;
            end
            expected_q.push_back(s);
        endfunction

        function void note_byte(logic [7:0] b);
            int bits;
            int shift;
            bit at_end;
            bytes_seen++;
            if (depth_code == ppsu_pkg::DEPTH_CODE_16) begin
                if (!wide) begin
                    hold_byte = b;
                    wide      = 1'b1;
                    return;
                end
                wide = 1'b0;
                push_sample({hold_byte, b}, at_end);
            end else begin
                // any other depth drops a held high byte
                wide = 1'b0;
                case (depth_code)
                    ppsu_pkg::DEPTH_CODE_1: bits = 1;
                    ppsu_pkg::DEPTH_CODE_2: bits = 2;
                    ppsu_pkg::DEPTH_CODE_4: bits = 4;
                    default:                bits = 8;
                endcase
                for (int k = 0; k < 8 / bits; k++) begin
                    shift = 8 - bits * (k + 1);
                    push_sample(16'((b >> shift) & ((1 << bits) - 1)), at_end);
                    if (at_end) break;
                end
            end
            expected_q[expected_q.size() - 1].last_b = 1'b1;
        endfunction

        function void field_check(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $realtime, name, exp_v, act_v);
            end
        endfunction

        function void check_sample(sample_t got);
            sample_t exp_s;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected sample, expected none actual %0h",
                         $realtime, got.value);
                return;
            end
            exp_s = expected_q.pop_front();
            checked++;
            field_check("sample", exp_s.value, got.value);
            field_check("channel_index", exp_s.chan, got.chan);
            field_check("pixel_index", exp_s.pix, got.pix);
            field_check("last_of_byte", exp_s.last_b, got.last_b);
            field_check("row_end", exp_s.row_end, got.row_end);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [ppsu_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [ppsu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_row_byte = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [15:0]                     m_sample;
    logic [1:0]                      m_channel_index;
    logic [11:0]                     m_pixel_index;
    logic                            m_last_of_byte;
    logic                            m_row_end;

    sample_scoreboard sb;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  pressure_on = 1'b0;
    bit  pressure_done = 1'b0;
    int  rx_hold_left = 0;
    int  phase_cnt = 0;

    packed_pixel_sample_unpacker_top #(
        .MAX_WIDTH(ROW_MAX)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_byte      (s_row_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_channel_index (m_channel_index),
        .m_pixel_index   (m_pixel_index),
        .m_last_of_byte  (m_last_of_byte),
        .m_row_end       (m_row_end)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off while pressure is on
    always @(negedge aclk) begin
        if (pressure_on && !pressure_done) begin
            rx_hold_left  = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        sample_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_row_byte);
            if (m_valid && m_ready) begin
                got.value   = m_sample;
                got.chan    = m_channel_index;
                got.pix     = m_pixel_index;
                got.last_b  = m_last_of_byte;
                got.row_end = m_row_end;
                sb.check_sample(got);
            end
        end
    end

    task automatic write_reg(input logic [ppsu_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ppsu_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_row_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_phase(input bit do_cfg, input logic [2:0] dc, input logic [2:0] cc,
                             input logic [12:0] rw, input idle_mode_t mode,
                             input row_bytes_t data);
        if (do_cfg) begin
            write_reg(ppsu_pkg::REG_DEPTH_CODE, 13'(dc));
            write_reg(ppsu_pkg::REG_CHANNEL_COUNT, 13'(cc));
            write_reg(ppsu_pkg::REG_ROW_WIDTH, rw);
            cfg_wr_en <= 1'b0;
        end
        case (mode)
            IDLE_SENDER:   begin tx_idle_pct = 72; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
            IDLE_BOTH:     begin tx_idle_pct = 36; rx_stall_pct = 36; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
        foreach (data[i]) send_byte(data[i]);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        // a high byte leaves nothing queued but may still be in flight
        repeat (SETTLE_CYCLES) @(negedge aclk);
        phase_cnt++;
    endtask

    initial begin
        #3_200_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        row_bytes_t  seq;
        logic [2:0]  dc;
        logic [2:0]  cc;
        logic [12:0] rw;
        int          len;
        int          pick;

        sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset settings, each depth, padding drop, clamped and spare codes,
        // mid-row change, held high byte dropped on leaving 16 bits
        seq = '{8'hFF, 8'h00};
        run_phase(1'b0, ppsu_pkg::DEPTH_CODE_8, 3'd1, 13'd1, IDLE_NONE, seq);
        seq = '{8'hA5, 8'h5A};
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_1, 3'd3, 13'd5, IDLE_NONE, seq);
        seq = '{8'h1B, 8'hE4, 8'hFF};
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_2, 3'd4, 13'd3, IDLE_RECEIVER, seq);
        seq = '{8'h80, 8'h01};
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_4, 3'd2, 13'd4096, IDLE_SENDER, seq);
        seq = '{8'hFF, 8'hFF, 8'h00, 8'h01, 8'hAB};
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_16, 3'd0, 13'd0, IDLE_BOTH, seq);
        seq = '{8'h7E, 8'h81};
        run_phase(1'b1, DEPTH_CODE_SPARE5, 3'd7, 13'd8191, IDLE_NONE, seq);
        seq = '{8'h3C};
        run_phase(1'b1, DEPTH_CODE_SPARE6, 3'd5, 13'd4097, IDLE_NONE, seq);
        seq = '{8'hC3, 8'h99};
        run_phase(1'b1, DEPTH_CODE_SPARE7, 3'd1, 13'd2, IDLE_RECEIVER, seq);
        seq = '{8'h12, 8'h34, 8'h56, 8'h78};
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_16, 3'd3, 13'd2, IDLE_NONE, seq);

        // Long receiver hold-off while bytes keep coming at one bit per sample
        seq.delete();
        repeat (20) seq.push_back(8'($urandom));
        pressure_on = 1'b1;
        run_phase(1'b1, ppsu_pkg::DEPTH_CODE_1, 3'd2, 13'd7, IDLE_NONE, seq);
        pressure_on = 1'b0;

        // Random settings; phases often end mid-row or with a held high byte
        while (sb.bytes_seen < RANDOM_BYTES) begin
            pick = $urandom_range(9);
            dc = (pick == 0)
                ? 3'($urandom_range(DEPTH_CODE_SPARE5, DEPTH_CODE_SPARE7))
                : 3'($urandom_range(ppsu_pkg::DEPTH_CODE_1, ppsu_pkg::DEPTH_CODE_16));
            cc = ($urandom_range(9) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(1, 4));
            pick = $urandom_range(19);
            if (pick == 0)      rw = 13'd0;
            else if (pick == 1) rw = 13'($urandom_range(4097, 8191));
            else if (pick == 2) rw = 13'd4096;
            else                rw = 13'($urandom_range(1, 12));
            len = $urandom_range(4, 20);
            seq.delete();
            repeat (len) seq.push_back(8'($urandom));
            run_phase(1'b1, dc, cc, rw, idle_mode_t'(phase_cnt % 4), seq);
        end

        $display("Covered %0d scanline bytes and %0d samples over %0d register settings,",
                 sb.bytes_seen, sb.checked, phase_cnt);
        $display("all depths, clamped widths and channel counts, stalls on either side.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
